>>> rtl/fv3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fv3_pkg
// Shared constants and types for the fixed-point 3D vector unit.
// ----------------------------------------------------------------------------
package fv3_pkg;
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int QUO_W     = NUM_W;
  localparam int LAT       = 4 + SQ_STEPS + QUO_W;

  typedef enum logic [1:0] {
    FUNC_MAG   = 2'd0,
    FUNC_NORM  = 2'd1,
    FUNC_CROSS = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  func;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        zl;
    logic        ovf;
  } flow_t;
endpackage
`default_nettype wire

>>> rtl/fv3_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fv3_div_lane
// Pipelined restoring divider, one quotient bit per stage: sign(c)*(|c|<<F)/m.
// ----------------------------------------------------------------------------
module fv3_div_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] comp,
  input  wire logic [31:0] mag,
  output logic      [31:0] quo
);
  localparam int N = fv3_pkg::QUO_W;

  logic [N-1:0] num_r [N+1];
  logic [N:0]   rem_r [N+1];
  logic [31:0]  den_r [N+1];
  logic         neg_r [N+1];

  always_comb begin
    num_r[0] = {(comp[31] ? (~comp + 32'd1) : comp), {fv3_pkg::FRAC_BITS{1'b0}}};
    rem_r[0] = '0;
    den_r[0] = mag;
    neg_r[0] = comp[31];
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N:0] t;
    logic [N:0] d;
    always_comb begin
      t = {rem_r[i][N-1:0], num_r[i][N-1]};
      d = {{(N+1-32){1'b0}}, den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
        if (t >= d) begin
          rem_r[i+1] <= t - d;
          num_r[i+1] <= {num_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= t;
          num_r[i+1] <= {num_r[i][N-2:0], 1'b0};
        end
      end
    end
  end

  // quotient <= 2^31 in magnitude when |c| <= m
  assign quo = neg_r[N] ? (~num_r[N][31:0] + 32'd1) : num_r[N][31:0];
endmodule
`default_nettype wire

>>> rtl/fv3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fv3_front
// Per-lane squares/products, sum of squares, cross terms with saturation,
// then a pipelined bit-per-stage integer square root and a select stage.
// ----------------------------------------------------------------------------
module fv3_front (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire logic [1:0]   func,
  input  wire logic [31:0]  ax,
  input  wire logic [31:0]  ay,
  input  wire logic [31:0]  az,
  input  wire logic [31:0]  bx,
  input  wire logic [31:0]  by,
  input  wire logic [31:0]  bz,
  output fv3_pkg::flow_t    flow,
  output logic [31:0]       mag,
  output logic [31:0]       oax,
  output logic [31:0]       oay,
  output logic [31:0]       oaz
);
  localparam int F = fv3_pkg::FRAC_BITS;
  localparam int S = fv3_pkg::SQ_STEPS;

  // stage 1: products
  logic [63:0] sq_r [3];
  logic signed [63:0] pr_r [6];
  fv3_pkg::flow_t f1_r, f2_r, f3_r;
  logic [31:0] a1_r [3];
  logic [31:0] a2_r [3];
  logic [31:0] a3_r [3];
  logic [31:0] ua [3];
  logic [63:0] sum2_r;
  logic signed [64:0] cr [3];
  logic [31:0] cv [3];
  logic [2:0]  co;

  always_comb begin
    ua[0] = ax[31] ? (~ax + 32'd1) : ax;
    ua[1] = ay[31] ? (~ay + 32'd1) : ay;
    ua[2] = az[31] ? (~az + 32'd1) : az;
  end

  always_ff @(posedge clk) begin
    if (!en) begin
    end else begin
      for (int i = 0; i < 3; i++) sq_r[i] <= {32'd0, ua[i]} * {32'd0, ua[i]};
      pr_r[0] <= $signed(ay) * $signed(bz);
      pr_r[1] <= $signed(az) * $signed(by);
      pr_r[2] <= $signed(az) * $signed(bx);
      pr_r[3] <= $signed(ax) * $signed(bz);
      pr_r[4] <= $signed(ax) * $signed(by);
      pr_r[5] <= $signed(ay) * $signed(bx);
      a1_r[0] <= ax; a1_r[1] <= ay; a1_r[2] <= az;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = {pr_r[2*i][63], pr_r[2*i] >>> F} - {pr_r[2*i+1][63], pr_r[2*i+1] >>> F};
      if (cr[i] > 65'sd2147483647) begin
        cv[i] = 32'h7FFFFFFF; co[i] = 1'b1;
      end else if (cr[i] < -65'sd2147483648) begin
        cv[i] = 32'h80000000; co[i] = 1'b1;
      end else begin
        cv[i] = cr[i][31:0]; co[i] = 1'b0;
      end
    end
  end

  // stage 2: merge lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sum2_r <= ((sq_r[0] >> F) + (sq_r[1] >> F) + (sq_r[2] >> F)) << F;
      f2_r.vld  <= f1_r.vld;
      f2_r.func <= f1_r.func;
      f2_r.x    <= cv[0];
      f2_r.y    <= cv[1];
      f2_r.z    <= cv[2];
      f2_r.zl   <= 1'b0;
      f2_r.ovf  <= |co;
      a2_r <= a1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r.vld  <= in_vld;
      f1_r.func <= func;
      f1_r.x <= '0; f1_r.y <= '0; f1_r.z <= '0;
      f1_r.zl <= 1'b0; f1_r.ovf <= 1'b0;
    end
  end

  // sqrt pipeline: bit-pair per stage, remainder/root form
  logic [63:0] v_r   [S+1];
  logic [32:0] q_r   [S+1];
  logic [34:0] rm_r  [S+1];
  fv3_pkg::flow_t fs_r [S+1];
  logic [31:0] as_r  [S+1][3];

  always_comb begin
    v_r[0]  = sum2_r;
    q_r[0]  = '0;
    rm_r[0] = '0;
    fs_r[0] = f2_r;
    as_r[0] = a2_r;
  end

  for (genvar i = 0; i < S; i++) begin : g_sq
    logic [34:0] t, d;
    always_comb begin
      t = {rm_r[i][32:0], v_r[i][63:62]};
      d = {q_r[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[i+1]  <= {v_r[i][61:0], 2'b00};
        fs_r[i+1] <= fs_r[i];
        as_r[i+1] <= as_r[i];
        if (t >= d) begin
          rm_r[i+1] <= t - d;
          q_r[i+1]  <= {q_r[i][31:0], 1'b1};
        end else begin
          rm_r[i+1] <= t;
          q_r[i+1]  <= {q_r[i][31:0], 1'b0};
        end
      end
    end
  end

  // stage after sqrt: apply magnitude result
  logic [32:0] m;
  assign m = q_r[S];
  always_ff @(posedge clk) begin
    if (en) begin
      f3_r <= fs_r[S];
      a3_r <= as_r[S];
      mag  <= m[32] ? 32'h7FFFFFFF : m[31:0];
      case (fs_r[S].func)
        fv3_pkg::FUNC_MAG: begin
          f3_r.x   <= (m[32] | m[31]) ? 32'h7FFFFFFF : m[31:0];
          f3_r.y   <= '0;
          f3_r.z   <= '0;
          f3_r.zl  <= (m == '0);
          f3_r.ovf <= m[32] | m[31];
        end
        fv3_pkg::FUNC_NORM: begin
          f3_r.zl  <= (m == '0);
          f3_r.ovf <= 1'b0;
        end
        fv3_pkg::FUNC_CROSS: begin
        end
        default: begin
          f3_r.x <= '0; f3_r.y <= '0; f3_r.z <= '0;
          f3_r.zl <= 1'b0; f3_r.ovf <= 1'b0;
        end
      endcase
    end
  end

  assign flow = f3_r;
  assign oax = a3_r[0];
  assign oay = a3_r[1];
  assign oaz = a3_r[2];
endmodule
`default_nettype wire

>>> rtl/fixed_vector3_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_vector3_unit_top
// Magnitude, normalize and cross for signed 16.16 3D vectors.
// ----------------------------------------------------------------------------
// Pipeline: product and merge stages, square-root stages, a select stage,
//   divide stages and an output register.
// Throughput: one request per cycle; the pipeline advances while the output
//   register is empty or being taken.
// Reset: synchronous active-low rst_n clears the valid shift line and out_valid.
module fixed_vector3_unit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_a_x,
  input  wire logic [31:0] in_a_y,
  input  wire logic [31:0] in_a_z,
  input  wire logic [31:0] in_b_x,
  input  wire logic [31:0] in_b_y,
  input  wire logic [31:0] in_b_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_r_x,
  output logic [31:0]      out_r_y,
  output logic [31:0]      out_r_z,
  output logic             out_zero_length,
  output logic             out_overflow
);
  localparam int DL = fv3_pkg::QUO_W;

  logic en;
  fv3_pkg::flow_t fl;
  logic [31:0] mag, ax, ay, az, qx, qy, qz;
  fv3_pkg::flow_t dq_r [DL];

  // whole pipe stalls together; payload stages follow en, valids tracked here
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  fv3_front u_front (
    .clk(clk), .en(en), .in_vld(in_valid), .func(in_func),
    .ax(in_a_x), .ay(in_a_y), .az(in_a_z),
    .bx(in_b_x), .by(in_b_y), .bz(in_b_z),
    .flow(fl), .mag(mag), .oax(ax), .oay(ay), .oaz(az)
  );

  // divider lanes, one per component; a zero magnitude is fixed up at the end
  fv3_div_lane u_dx (.clk(clk), .en(en), .comp(ax), .mag(mag), .quo(qx));
  fv3_div_lane u_dy (.clk(clk), .en(en), .comp(ay), .mag(mag), .quo(qy));
  fv3_div_lane u_dz (.clk(clk), .en(en), .comp(az), .mag(mag), .quo(qz));

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[0] <= fl;
      for (int i = 1; i < DL; i++) dq_r[i] <= dq_r[i-1];
    end
  end

  // valid shift line over all stages, reset cleared
  localparam int VL = 3 + fv3_pkg::SQ_STEPS + DL;
  logic [VL-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[VL-2:0], in_valid};
      out_valid <= v_r[VL-1];
    end
  end

  // merge stage
  fv3_pkg::flow_t t;
  assign t = dq_r[DL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      out_zero_length <= t.zl;
      out_overflow    <= t.ovf;
      if (t.func == fv3_pkg::FUNC_NORM && !t.zl) begin
        out_r_x <= qx; out_r_y <= qy; out_r_z <= qz;
      end else if (t.func == fv3_pkg::FUNC_NORM) begin
        out_r_x <= '0; out_r_y <= '0; out_r_z <= '0;
      end else begin
        out_r_x <= t.x; out_r_y <= t.y; out_r_z <= t.z;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r_x))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
  a_norm_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> !out_overflow)
    else $error("zero length with overflow");
endmodule
`default_nettype wire
